>>> hw/rtl/blcd_pkg.sv
// Shared types, constants and arithmetic helpers for the burst loss count distribution core.
`timescale 1ns / 1ps

package blcd_pkg;

   // Field and port widths
   localparam int SEQ_W       = 6;
   localparam int PROB_W      = 32;
   localparam int COEF_W      = 33;
   localparam int CFG_W       = 16;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 40;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int DEF_MAX_LEN = 64;

   // Register reset values
   localparam logic [CFG_W-1:0] ERROR_RATE_RST = 16'd6554;
   localparam logic [CFG_W-1:0] LOSS_CORR_RST  = 16'd32768;

   // Register index as decoded from csr_paddr[2]
   localparam logic REG_ERROR_RATE = 1'b0;
   localparam logic REG_LOSS_CORR  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STEP,
      ST_OUT
   } blcd_state_type;

   // Per-cycle command to every cell of the chain
   typedef struct packed {
      logic load;
      logic step;
      logic shift;
   } blcd_cell_ctrl_type;

   // Transition coefficients, fractions /2^32, up to 2^32
   typedef struct packed {
      logic [COEF_W-1:0] one_m_a;
      logic [COEF_W-1:0] one_m_b;
      logic [COEF_W-1:0] coef_a;
      logic [COEF_W-1:0] coef_b;
   } blcd_coef_type;

   // Probability times coefficient, truncated; result never exceeds p
   function automatic logic [PROB_W-1:0] mul_frac(input logic [PROB_W-1:0] p,
                                                  input logic [COEF_W-1:0] k);
      logic [PROB_W+COEF_W-1:0] prod;
      prod = (PROB_W+COEF_W)'(p) * (PROB_W+COEF_W)'(k);
      return prod[2*PROB_W-1:PROB_W];
   endfunction

   // Sum of two probabilities, saturating at all ones
   function automatic logic [PROB_W-1:0] sat_add(input logic [PROB_W-1:0] x,
                                                 input logic [PROB_W-1:0] y);
      logic [PROB_W:0] s;
      s = {1'b0, x} + {1'b0, y};
      return s[PROB_W] ? {PROB_W{1'b1}} : s[PROB_W-1:0];
   endfunction

endpackage

>>> hw/rtl/blcd_coef.sv
// Transition coefficient unit: derives 1-a, 1-b, a and b from the configured rates.
`timescale 1ns / 1ps

module blcd_coef (
   input  logic                            clock,
   input  logic [blcd_pkg::CFG_W-1:0]      error_rate,
   input  logic [blcd_pkg::CFG_W-1:0]      loss_correlation,
   output blcd_pkg::blcd_coef_type         coef
);

   localparam logic [blcd_pkg::CFG_W:0]    ONE16 = 17'h1_0000;
   localparam logic [blcd_pkg::COEF_W-1:0] ONE32 = 33'h1_0000_0000;

   logic [blcd_pkg::CFG_W:0]       one_m_pe;
   logic [blcd_pkg::CFG_W:0]       one_m_c;
   logic [2*blcd_pkg::CFG_W+1:0]   prod_a;
   logic [2*blcd_pkg::CFG_W+1:0]   prod_b;
   blcd_pkg::blcd_coef_type        coef_in;
   blcd_pkg::blcd_coef_type        coef_ff;

   // (1-pe)(1-c) and pe(1-c), exact in 33 bits
   always_comb begin
      one_m_pe       = ONE16 - {1'b0, error_rate};
      one_m_c        = ONE16 - {1'b0, loss_correlation};
      prod_a         = (2*blcd_pkg::CFG_W+2)'(one_m_pe) * (2*blcd_pkg::CFG_W+2)'(one_m_c);
      prod_b         = (2*blcd_pkg::CFG_W+2)'(error_rate) * (2*blcd_pkg::CFG_W+2)'(one_m_c);
      coef_in.one_m_a = prod_a[blcd_pkg::COEF_W-1:0];
      coef_in.one_m_b = prod_b[blcd_pkg::COEF_W-1:0];
      coef_in.coef_a  = ONE32 - prod_a[blcd_pkg::COEF_W-1:0];
      coef_in.coef_b  = ONE32 - prod_b[blcd_pkg::COEF_W-1:0];
   end

   // Registered; the user must keep config quiet while a request is in flight; the block does not enforce it
   always_ff @(posedge clock) begin
      coef_ff <= coef_in;
   end

   assign coef = coef_ff;

endmodule

>>> hw/rtl/blcd_cell.sv
// One loss-count cell: holds good/bad end probabilities, steps from its lower neighbor.
`timescale 1ns / 1ps

module blcd_cell (
   input  logic                               clock,
   input  blcd_pkg::blcd_cell_ctrl_type       ctrl,
   input  blcd_pkg::blcd_coef_type            coef,
   input  logic [blcd_pkg::PROB_W-1:0]        seed_g,
   input  logic [blcd_pkg::PROB_W-1:0]        seed_b,
   input  logic [blcd_pkg::PROB_W-1:0]        prev_g,
   input  logic [blcd_pkg::PROB_W-1:0]        prev_b,
   input  logic [blcd_pkg::PROB_W-1:0]        next_g,
   input  logic [blcd_pkg::PROB_W-1:0]        next_b,
   output logic [blcd_pkg::PROB_W-1:0]        g_out,
   output logic [blcd_pkg::PROB_W-1:0]        b_out
);

   logic [blcd_pkg::PROB_W-1:0] g_ff, g_in;
   logic [blcd_pkg::PROB_W-1:0] b_ff, b_in;
   logic [blcd_pkg::PROB_W-1:0] g_step;
   logic [blcd_pkg::PROB_W-1:0] b_step;

   // One packet: stay good or recover; lose from the neighbor with one less loss
   always_comb begin
      g_step = blcd_pkg::sat_add(blcd_pkg::mul_frac(g_ff, coef.coef_b),
                                 blcd_pkg::mul_frac(b_ff, coef.one_m_a));
      b_step = blcd_pkg::sat_add(blcd_pkg::mul_frac(prev_g, coef.one_m_b),
                                 blcd_pkg::mul_frac(prev_b, coef.coef_a));
   end

   // load seeds, step advances, shift moves toward cell 0 for readout
   always_comb begin
      g_in = g_ff;
      b_in = b_ff;
      if (ctrl.load) begin
         g_in = seed_g;
         b_in = seed_b;
      end else if (ctrl.step) begin
         g_in = g_step;
         b_in = b_step;
      end else if (ctrl.shift) begin
         g_in = next_g;
         b_in = next_b;
      end
   end

   always_ff @(posedge clock) begin
      g_ff <= g_in;
      b_ff <= b_in;
   end

   assign g_out = g_ff;
   assign b_out = b_ff;

endmodule

>>> hw/rtl/burst_loss_count_distribution_core.sv
// Top level: request/response streams, APB registers, sequencer and the chain of cells.
// Flow: with n = min(seq_len, MAX_LEN-1), a taken request seeds the chain, which then advances
// n packets; responses k = 0..n follow one per cycle while rsp_tready is high, read out by
// shifting toward cell 0. A new request is taken only after the last response of the one before.
// Reset: synchronous; clears the sequencer and restores the register defaults.
`timescale 1ns / 1ps

module burst_loss_count_distribution_core #(
   parameter int MAX_LEN = blcd_pkg::DEF_MAX_LEN
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request: [5:0] seq_len, [7:6] zero
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [blcd_pkg::REQ_DATA_W-1:0]       req_tdata,
   // response: [5:0] loss_count, [37:6] probability, [39:38] zero
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [blcd_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                  rsp_tlast,
   // register port
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [blcd_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [blcd_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [blcd_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);

   localparam int SW = blcd_pkg::SEQ_W;
   localparam int PW = blcd_pkg::PROB_W;
   localparam logic [SW-1:0] LEN_LIMIT = SW'(MAX_LEN - 1);

   // ---------------- registers ----------------
   logic [blcd_pkg::CFG_W-1:0] error_rate_ff, error_rate_in;
   logic [blcd_pkg::CFG_W-1:0] loss_corr_ff, loss_corr_in;
   logic                       csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      error_rate_in = error_rate_ff;
      loss_corr_in  = loss_corr_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            blcd_pkg::REG_ERROR_RATE: error_rate_in = csr_pwdata[blcd_pkg::CFG_W-1:0];
            default:                  loss_corr_in  = csr_pwdata[blcd_pkg::CFG_W-1:0];
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         blcd_pkg::REG_ERROR_RATE:
            csr_prdata = blcd_pkg::CSR_DATA_W'(error_rate_ff);
         default:
            csr_prdata = blcd_pkg::CSR_DATA_W'(loss_corr_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         error_rate_ff <= blcd_pkg::ERROR_RATE_RST;
         loss_corr_ff  <= blcd_pkg::LOSS_CORR_RST;
      end else begin
         error_rate_ff <= error_rate_in;
         loss_corr_ff  <= loss_corr_in;
      end
   end

   // ---------------- coefficients ----------------
   blcd_pkg::blcd_coef_type coef;

   blcd_coef u_coef (
      .clock            (clock),
      .error_rate       (error_rate_ff),
      .loss_correlation (loss_corr_ff),
      .coef             (coef)
   );

   // Seed: 1-pe for good, pe for bad; 1-pe saturates when pe is zero
   logic [blcd_pkg::CFG_W:0] seed_one_m_pe;
   logic [PW-1:0]            seed_g;
   logic [PW-1:0]            seed_b;

   always_comb begin
      seed_one_m_pe = 17'h1_0000 - {1'b0, error_rate_ff};
      seed_g = seed_one_m_pe[blcd_pkg::CFG_W] ? {PW{1'b1}}
                                               : {seed_one_m_pe[blcd_pkg::CFG_W-1:0], 16'h0000};
      seed_b = {error_rate_ff, 16'h0000};
   end

   // ---------------- sequencer ----------------
   blcd_pkg::blcd_state_type     state_ff, state_in;
   logic [SW-1:0]                len_ff, len_in;
   logic [SW-1:0]                cnt_ff, cnt_in;
   logic [SW-1:0]                idx_ff, idx_in;
   logic [SW-1:0]                req_len;
   blcd_pkg::blcd_cell_ctrl_type ctrl;

   assign req_len = (req_tdata[SW-1:0] > LEN_LIMIT) ? LEN_LIMIT : req_tdata[SW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= blcd_pkg::ST_IDLE;
         len_ff   <= '0;
         cnt_ff   <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         cnt_ff   <= cnt_in;
         idx_ff   <= idx_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      len_in     = len_ff;
      cnt_in     = cnt_ff;
      idx_in     = idx_ff;
      ctrl       = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         blcd_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ctrl.load = 1'b1;
               len_in    = req_len;
               cnt_in    = '0;
               idx_in    = '0;
               state_in  = (req_len == '0) ? blcd_pkg::ST_OUT : blcd_pkg::ST_STEP;
            end
         end
         blcd_pkg::ST_STEP: begin
            // every cell advances one packet per cycle
            ctrl.step = 1'b1;
            cnt_in    = cnt_ff + SW'(1);
            if (cnt_ff + SW'(1) == len_ff) begin
               state_in = blcd_pkg::ST_OUT;
            end
         end
         blcd_pkg::ST_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               ctrl.shift = 1'b1;
               idx_in     = idx_ff + SW'(1);
               if (idx_ff == len_ff) begin
                  state_in = blcd_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = blcd_pkg::ST_IDLE;
         end
      endcase
   end

   // ---------------- chain of cells ----------------
   logic [PW-1:0] cell_g [MAX_LEN];
   logic [PW-1:0] cell_b [MAX_LEN];

   for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
      logic [PW-1:0] prev_g, prev_b, next_g, next_b, sg, sb;

      if (k == 0) begin : g_first
         assign prev_g = '0;
         assign prev_b = '0;
         assign sg     = seed_g;
         assign sb     = seed_b;
      end else begin : g_rest
         assign prev_g = cell_g[k-1];
         assign prev_b = cell_b[k-1];
         assign sg     = '0;
         assign sb     = '0;
      end

      if (k == MAX_LEN - 1) begin : g_tail
         assign next_g = '0;
         assign next_b = '0;
      end else begin : g_body
         assign next_g = cell_g[k+1];
         assign next_b = cell_b[k+1];
      end

      blcd_cell u_cell (
         .clock  (clock),
         .ctrl   (ctrl),
         .coef   (coef),
         .seed_g (sg),
         .seed_b (sb),
         .prev_g (prev_g),
         .prev_b (prev_b),
         .next_g (next_g),
         .next_b (next_b),
         .g_out  (cell_g[k]),
         .b_out  (cell_b[k])
      );
   end

   // ---------------- response ----------------
   logic [PW-1:0] prob;

   assign prob      = blcd_pkg::sat_add(cell_g[0], cell_b[0]);
   assign rsp_tdata = {2'b00, prob, idx_ff};
   assign rsp_tlast = (idx_ff == len_ff);

   // ---------------- checks ----------------
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready)
      else $error("request not released after last response");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("new request taken while one is in flight");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> idx_ff <= len_ff)
      else $error("response index beyond request length");

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == blcd_pkg::ST_STEP |-> cnt_ff < len_ff && len_ff <= LEN_LIMIT)
      else $error("step counter out of range");

endmodule
